// ===== design/skt_pkg.sv =====
`default_nettype none

package skt_pkg;

  localparam int DEPTH     = 128;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KEY_W     = 31;
  localparam int PAY_W     = 20;
  localparam int REC_W     = KEY_W + PAY_W;
  localparam int OUT_IDX_W = 7;
  localparam int OUT_CNT_W = 8;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_FIRST  = 3'd3,
    CMD_LAST   = 3'd4,
    CMD_NEXT   = 3'd5,
    CMD_PREV   = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_MISS  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PROBE,
    S_CMP,
    S_RESOLVE,
    S_SHIFT,
    S_PLACE,
    S_READ,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    bs_init;
    logic    probe;
    logic    cmp;
    logic    sh_init;
    logic    sh_step;
    logic    place;
    logic    del_commit;
    logic    set_cur_lo;
    logic    move;
    logic    rd_cur;
    logic    st_we;
    status_t st_code;
    logic    out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic bs_done;
    logic found;
    logic sh_more;
    logic at_first;
    logic at_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/sorted_key_table_with_cursor.sv =====
`default_nettype none
// Steps, input transfer to result transfer: every command has dispatch, cursor read and
//   output load; search adds probe/compare pairs and a resolve; insert adds to search a
//   shift step per moved record and a place; delete, one per record above the cursor.
// Throughput: one item at a time; the next is taken the cycle after the result is
//   loaded into the output register, even while that result waits for out_ready.
// Reset: synchronous active-low rst_n empties the table and homes the cursor; RAM kept.

module sorted_key_table_with_cursor
  import skt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_cmd,
  input  wire logic [KEY_W-1:0]     in_key,
  input  wire logic [PAY_W-1:0]     in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_status,
  output logic [KEY_W-1:0]          out_cur_key,
  output logic [PAY_W-1:0]          out_cur_payload,
  output logic [OUT_IDX_W-1:0]      out_cur_index,
  output logic [OUT_CNT_W-1:0]      out_entry_count
);

  // The controller sequences each command: binary search as probe/compare pairs
  // against the record RAM, then a one-record-per-cycle shift (read one slot,
  // write its neighbor the following cycle), then a final cursor read that
  // feeds the output register.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Datapath holds the records, count, cursor, search bounds and the result
  // register; the result register lets a new transfer in while it waits.
  skt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_cur_key     (out_cur_key),
    .out_cur_payload (out_cur_payload),
    .out_cur_index   (out_cur_index),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

// ===== design/skt_ram.sv =====
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/skt_dp.sv =====
`default_nettype none

module skt_dp
  import skt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic [2:0]           in_cmd,
  input  wire logic [KEY_W-1:0]     in_key,
  input  wire logic [PAY_W-1:0]     in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_status,
  output logic [KEY_W-1:0]          out_cur_key,
  output logic [PAY_W-1:0]          out_cur_payload,
  output logic [OUT_IDX_W-1:0]      out_cur_index,
  output logic [OUT_CNT_W-1:0]      out_entry_count
);

  cmd_t              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [PAY_W-1:0]  pay_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic              wpend_r;
  logic [IDX_W-1:0]  waddr_r;
  status_t           status_r;
  logic              out_valid_r;

  logic [CNT_W-1:0]  mid_calc, src, cur_ext;
  logic              sh_more, at_last;
  logic [REC_W-1:0]  rdata, wdata;
  logic [KEY_W-1:0]  rd_key;
  logic [PAY_W-1:0]  rd_pay;
  logic              re, we;
  logic [IDX_W-1:0]  raddr, waddr;

  assign cur_ext  = CNT_W'(cursor_r);
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key   = rdata[REC_W-1 -: KEY_W];
  assign rd_pay   = rdata[PAY_W-1:0];
  assign at_last  = (cur_ext + CNT_W'(1)) >= count_r;

  // insert moves records up from the top, delete pulls them down from the cursor
  assign sh_more = (cmd_r == CMD_INSERT) ? (idx_r > lo_r)
                                         : ((idx_r + CNT_W'(1)) < count_r);
  assign src     = (cmd_r == CMD_INSERT) ? (idx_r - CNT_W'(1)) : (idx_r + CNT_W'(1));

  assign stat.cmd      = cmd_r;
  assign stat.full     = (count_r >= CNT_W'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.bs_done  = (lo_r >= hi_r);
  assign stat.found    = found_r;
  assign stat.sh_more  = sh_more;
  assign stat.at_first = (cursor_r == '0);
  assign stat.at_last  = at_last;
  assign stat.out_busy = out_valid_r && !out_ready;

  // memory port steering
  always_comb begin
    re    = 1'b0;
    raddr = cursor_r;
    if (cmd.probe) begin
      re    = 1'b1;
      raddr = mid_calc[IDX_W-1:0];
    end else if (cmd.sh_step && sh_more) begin
      re    = 1'b1;
      raddr = src[IDX_W-1:0];
    end else if (cmd.rd_cur) begin
      re    = 1'b1;
    end
    we    = wpend_r || cmd.place;
    waddr = wpend_r ? waddr_r : lo_r[IDX_W-1:0];
    wdata = wpend_r ? rdata : {key_r, pay_r};
  end

  skt_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    found_nxt  = found_r;
    idx_nxt    = idx_r;
    if (cmd.bs_init) begin
      lo_nxt    = '0;
      hi_nxt    = count_r;
      found_nxt = 1'b0;
    end
    if (cmd.cmp) begin
      if (rd_key < key_r) begin
        lo_nxt = mid_r + CNT_W'(1);
      end else begin
        hi_nxt = mid_r;
      end
      if (rd_key == key_r) begin
        found_nxt = 1'b1;
      end
    end
    if (cmd.sh_init) begin
      idx_nxt = (cmd_r == CMD_INSERT) ? count_r : cur_ext;
    end
    if (cmd.sh_step && sh_more) begin
      idx_nxt = src;
    end
    if (cmd.place) begin
      count_nxt  = count_r + CNT_W'(1);
      cursor_nxt = lo_r[IDX_W-1:0];
    end
    if (cmd.set_cur_lo) begin
      cursor_nxt = lo_r[IDX_W-1:0];
    end
    if (cmd.del_commit) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_nxt == '0) begin
        cursor_nxt = '0;
      end else if (cur_ext == count_nxt) begin
        cursor_nxt = cursor_r - IDX_W'(1);
      end
    end
    if (cmd.move) begin
      case (cmd_r)
        CMD_FIRST: cursor_nxt = '0;
        CMD_LAST:  cursor_nxt = IDX_W'(count_r - CNT_W'(1));
        CMD_NEXT:  if (!at_last) cursor_nxt = cursor_r + IDX_W'(1);
        CMD_PREV:  if (cursor_r != '0) cursor_nxt = cursor_r - IDX_W'(1);
        default:   cursor_nxt = cursor_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      wpend_r  <= cmd.sh_step && sh_more;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    waddr_r <= idx_r[IDX_W-1:0];
    if (cmd.probe) begin
      mid_r <= mid_calc;
    end
    if (cmd.load) begin
      cmd_r    <= cmd_t'(in_cmd);
      key_r    <= in_key;
      pay_r    <= in_payload;
      status_r <= ST_OK;
    end else if (cmd.st_we) begin
      status_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_status      <= status_r;
      out_entry_count <= OUT_CNT_W'(count_r);
      if (count_r != '0) begin
        out_cur_key     <= rd_key;
        out_cur_payload <= rd_pay;
        out_cur_index   <= OUT_IDX_W'(cursor_r);
      end else begin
        out_cur_key     <= '0;
        out_cur_payload <= '0;
        out_cur_index   <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("record count above table depth");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> cur_ext < count_r)
    else $error("cursor beyond last record");

  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> cursor_r == '0)
    else $error("cursor not at zero on empty table");

  a_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wpend_r && cmd.place))
    else $error("shift write and record placement in one cycle");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(cmd.place) || $past(cmd.del_commit))
    else $error("record count changed outside insert or delete");

endmodule

`default_nettype wire

// ===== design/skt_ctrl.sv =====
`default_nettype none

module skt_ctrl
  import skt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_code = ST_OK;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_READ;
        if (stat.cmd == CMD_INSERT) begin
          if (stat.full) begin
            cmd.st_we   = 1'b1;
            cmd.st_code = ST_FULL;
          end else begin
            cmd.bs_init = 1'b1;
            state_nxt   = S_PROBE;
          end
        end else if (stat.empty) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_EMPTY;
        end else begin
          case (stat.cmd)
            CMD_DELETE: begin
              cmd.sh_init = 1'b1;
              state_nxt   = S_SHIFT;
            end
            CMD_SEARCH: begin
              cmd.bs_init = 1'b1;
              state_nxt   = S_PROBE;
            end
            CMD_NEXT: begin
              cmd.move    = 1'b1;
              cmd.st_we   = stat.at_last;
              cmd.st_code = ST_MISS;
            end
            CMD_PREV: begin
              cmd.move    = 1'b1;
              cmd.st_we   = stat.at_first;
              cmd.st_code = ST_MISS;
            end
            default: cmd.move = 1'b1;
          endcase
        end
      end
      S_PROBE: begin
        if (stat.bs_done) begin
          state_nxt = S_RESOLVE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_PROBE;
      end
      S_RESOLVE: begin
        state_nxt = S_READ;
        if (stat.cmd == CMD_INSERT) begin
          if (stat.found) begin
            cmd.st_we   = 1'b1;
            cmd.st_code = ST_DUP;
          end else begin
            cmd.sh_init = 1'b1;
            state_nxt   = S_SHIFT;
          end
        end else if (stat.found) begin
          cmd.set_cur_lo = 1'b1;
        end else begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_MISS;
        end
      end
      S_SHIFT: begin
        cmd.sh_step = 1'b1;
        if (!stat.sh_more) begin
          if (stat.cmd == CMD_INSERT) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.del_commit = 1'b1;
            state_nxt      = S_READ;
          end
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DISPATCH)
    else $error("item taken without dispatch");

  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $past(cmd.rd_cur) || $past(state_r) == S_OUT)
    else $error("result loaded without a cursor read");

  a_probe_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |=> cmd.cmp)
    else $error("probe not followed by compare");

endmodule

`default_nettype wire

// ===== test/sorted_key_table_with_cursor_test.sv =====
module sorted_key_table_with_cursor_test;
  import skt_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [PAY_W-1:0] PAY_MAX = {PAY_W{1'b1}};
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_OFF_AFTER = 500;  // reports seen before the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;    // covers a full-depth insert after the last report
  localparam int PRINT_CAP = 30;

  // Stimulus phases: grow the table to full, churn it, then shrink it to empty.
  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  // One report from the block, as predicted or as observed.
  typedef struct packed {
    logic [2:0]           status;
    logic [KEY_W-1:0]     cur_key;
    logic [PAY_W-1:0]     cur_payload;
    logic [OUT_IDX_W-1:0] cur_index;
    logic [OUT_CNT_W-1:0] entry_count;
  } report_t;

  // Mirror of the sorted table: predicts each report on transfer of a command
  // and checks the block's reports against them in order.
  class table_mirror;
    logic [KEY_W-1:0] keys [DEPTH];
    logic [PAY_W-1:0] pays [DEPTH];
    int               count;
    int               cursor;
    report_t          pending [$];
    int               mismatches;
    int               reports_checked;
    int               cmd_seen [8];
    int               status_seen [5];
    int               times_full;
    int               times_emptied;

    function new();
      count = 0;
      cursor = 0;
      mismatches = 0;
      reports_checked = 0;
      times_full = 0;
      times_emptied = 0;
    endfunction

    // First position whose key is not below k.
    function int lower_pos(logic [KEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_command(cmd_t c, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
      status_t st;
      int      pos;
      report_t r;
      st = ST_OK;
      cmd_seen[c]++;
      if (c == CMD_INSERT) begin
        if (count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          pos = lower_pos(k);
          if (pos < count && keys[pos] == k) begin
            st = ST_DUP;
          end else begin
            for (int i = count; i > pos; i--) begin
              keys[i] = keys[i-1];
              pays[i] = pays[i-1];
            end
            keys[pos] = k;
            pays[pos] = p;
            count++;
            cursor = pos;
            if (count == DEPTH) times_full++;
          end
        end
      end else if (count == 0) begin
        st = ST_EMPTY;
      end else begin
        if (cursor >= count) cursor = count - 1;
        case (c)
          CMD_DELETE: begin
            for (int i = cursor; i + 1 < count; i++) begin
              keys[i] = keys[i+1];
              pays[i] = pays[i+1];
            end
            count--;
            if (count == 0) begin
              cursor = 0;
              times_emptied++;
            end else if (cursor == count) begin
              cursor--;
            end
          end
          CMD_SEARCH: begin
            pos = lower_pos(k);
            if (pos < count && keys[pos] == k) cursor = pos;
            else st = ST_MISS;
          end
          CMD_FIRST: cursor = 0;
          CMD_LAST:  cursor = count - 1;
          CMD_NEXT: begin
            if (cursor + 1 >= count) st = ST_MISS;
            else cursor++;
          end
          CMD_PREV: begin
            if (cursor == 0) st = ST_MISS;
            else cursor--;
          end
          default: ;
        endcase
      end
      r.status = st;
      if (count > 0) begin
        r.cur_key = keys[cursor];
        r.cur_payload = pays[cursor];
        r.cur_index = cursor[OUT_IDX_W-1:0];
      end else begin
        r.cur_key = '0;
        r.cur_payload = '0;
        r.cur_index = '0;
      end
      r.entry_count = count[OUT_CNT_W-1:0];
      status_seen[st]++;
      pending.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: report with no command outstanding, expected none, actual status %0d",
                   $time, got.status);
        return;
      end
      want = pending.pop_front();
      reports_checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("cur_key", 32'(want.cur_key), 32'(got.cur_key));
      compare_field("cur_payload", 32'(want.cur_payload), 32'(got.cur_payload));
      compare_field("cur_index", 32'(want.cur_index), 32'(got.cur_index));
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           in_cmd;
  logic [KEY_W-1:0]     in_key;
  logic [PAY_W-1:0]     in_payload;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_status;
  logic [KEY_W-1:0]     out_cur_key;
  logic [PAY_W-1:0]     out_cur_payload;
  logic [OUT_IDX_W-1:0] out_cur_index;
  logic [OUT_CNT_W-1:0] out_entry_count;

  table_mirror table_model = new();
  int          burst_left = 0;

  sorted_key_table_with_cursor DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_cur_key     (out_cur_key),
    .out_cur_payload (out_cur_payload),
    .out_cur_index   (out_cur_index),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one command, hold it until transfer, note it in the mirror, then
  // close the burst with a random gap, possibly empty, when the burst runs out.
  task automatic send_command(input cmd_t c, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] p);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= c;
    in_key <= k;
    in_payload <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_model.note_command(c, k, p);
    burst_left--;
    if (burst_left <= 0) begin
      // Long bursts now and then, short ones otherwise; most bursts end in an idle gap.
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Pick a key: often one already held (duplicates, search hits), sometimes a
  // neighbor of one (probes both sides of the binary search), else the
  // extremes, a crowded low range, or any 31-bit value.
  function automatic logic [KEY_W-1:0] pick_key(int held_pct);
    int r;
    logic [KEY_W-1:0] held;
    r = $urandom_range(99);
    if (table_model.count > 0) begin
      held = table_model.keys[$urandom_range(table_model.count - 1)];
      if (r < held_pct) return held;
      if (r < held_pct + 10) return ($urandom_range(1) != 0) ? held + 1'b1 : held - 1'b1;
    end
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return KEY_MAX;
    if (r < 45) return KEY_W'($urandom_range(400));
    return KEY_W'($urandom);
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return PAY_MAX;
    return PAY_W'($urandom);
  endfunction

  // Weight the command mix by phase: fill favors insert, drain favors delete.
  function automatic cmd_t pick_command(phase_t ph);
    int r;
    int ins_pct;
    int del_pct;
    r = $urandom_range(99);
    case (ph)
      PH_FILL:  begin ins_pct = 75; del_pct = 5;  end
      PH_DRAIN: begin ins_pct = 10; del_pct = 60; end
      default:  begin ins_pct = 35; del_pct = 20; end
    endcase
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + del_pct) return CMD_DELETE;
    return cmd_t'($urandom_range(int'(CMD_SEARCH), int'(CMD_READ)));
  endfunction

  // Sample every result transfer at the clock edge and check it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      table_model.check_report({out_status, out_cur_key, out_cur_payload,
                                out_cur_index, out_entry_count});
  end

  // Receiver: run a changing stall pattern, and once hold off for a long
  // stretch so the output register fills and the block stops taking commands.
  initial begin : result_sink
    int mode;
    int mode_left;
    int stall_left;
    int tick;
    bit held_off;
    logic [15:0] pattern;
    out_ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    tick = 0;
    held_off = 1'b0;
    pattern = '1;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held_off && table_model.reports_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(3);
          mode_left = $urandom_range(64, 256);
          pattern = 16'($urandom) | 16'h0001;
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= pattern[tick % 16];
          2: out_ready <= ($urandom_range(99) >= 30);
          default: begin
            // Mostly ready, with occasional stalls.
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else if ($urandom_range(15) == 0) begin
              stall_left = $urandom_range(5, 20);
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    phase_t ph;
    int     phase_left;
    int     sent;
    int     held_pct;
    cmd_t   c;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_READ;
    in_key <= '0;
    in_payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every non-insert command on an empty table reports empty.
    send_command(CMD_DELETE, KEY_MAX, PAY_MAX);
    send_command(CMD_SEARCH, '0, '0);
    send_command(CMD_FIRST, '0, '0);
    send_command(CMD_LAST, '0, '0);
    send_command(CMD_NEXT, '0, '0);
    send_command(CMD_PREV, '0, '0);
    send_command(CMD_READ, '0, '0);
    // Delete the only record: table empties and the cursor homes.
    send_command(CMD_INSERT, KEY_W'(5), PAY_W'(9));
    send_command(CMD_DELETE, '0, '0);
    // Extreme keys and payloads, a duplicate, and a record in between.
    send_command(CMD_INSERT, '0, '0);
    send_command(CMD_INSERT, KEY_MAX, PAY_MAX);
    send_command(CMD_INSERT, '0, PAY_MAX);
    send_command(CMD_INSERT, KEY_W'(1000), PAY_W'(20'h55555));
    // Search hit and miss.
    send_command(CMD_SEARCH, KEY_MAX, '0);
    send_command(CMD_SEARCH, KEY_W'(7), '0);
    // Step off both ends.
    send_command(CMD_FIRST, '0, '0);
    send_command(CMD_PREV, '0, '0);
    send_command(CMD_LAST, '0, '0);
    send_command(CMD_NEXT, '0, '0);
    // Delete the last record: the cursor steps back.
    send_command(CMD_DELETE, '0, '0);
    send_command(CMD_READ, '0, '0);

    // Random part: cycle fill, churn and drain so the table runs full and empty.
    ph = PH_FILL;
    phase_left = $urandom_range(6, 16);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      c = pick_command(ph);
      held_pct = (c == CMD_SEARCH) ? 60 : ((ph == PH_FILL) ? 10 : 25);
      send_command(c, pick_key(held_pct), pick_payload());
      sent++;
      // Fill and drain phases count down only once they reach full or empty.
      if ((ph == PH_FILL && table_model.count == DEPTH) ||
          (ph == PH_DRAIN && table_model.count == 0) || ph == PH_MIX)
        phase_left--;
      if (phase_left <= 0) begin
        case (ph)
          PH_FILL:  begin ph = PH_MIX;   phase_left = $urandom_range(100, 200); end
          PH_MIX:   begin ph = PH_DRAIN; phase_left = $urandom_range(3, 8);     end
          default:  begin ph = PH_FILL;  phase_left = $urandom_range(6, 16);    end
        endcase
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding reports, then watch for strays.
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_model.pending.size() != 0) begin
      table_model.mismatches++;
      $display("%0t: %0d reports never arrived, expected 0 outstanding",
               $time, table_model.pending.size());
    end

    $display("Checked %0d reports: %0d inserts, %0d deletes, %0d searches, %0d moves/reads.",
             table_model.reports_checked, table_model.cmd_seen[CMD_INSERT],
             table_model.cmd_seen[CMD_DELETE], table_model.cmd_seen[CMD_SEARCH],
             table_model.reports_checked - table_model.cmd_seen[CMD_INSERT]
               - table_model.cmd_seen[CMD_DELETE] - table_model.cmd_seen[CMD_SEARCH]);
    $display("Table ran full %0d and empty %0d times; ok/full/dup/empty/miss = %0d/%0d/%0d/%0d/%0d.",
             table_model.times_full, table_model.times_emptied,
             table_model.status_seen[ST_OK], table_model.status_seen[ST_FULL],
             table_model.status_seen[ST_DUP], table_model.status_seen[ST_EMPTY],
             table_model.status_seen[ST_MISS]);
    if (table_model.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("%0t: timeout with %0d reports outstanding", $time, table_model.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/skt_pkg.sv
design/skt_ram.sv
design/skt_dp.sv
design/skt_ctrl.sv
design/sorted_key_table_with_cursor.sv
test/sorted_key_table_with_cursor_test.sv
